// File: rtl/core/ffd_pkg.sv
// Package with the field layouts, status codes and byte-count helper of the request packer.
package ffd_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int MAX_REQUESTS = 32;
  localparam int BIDX_W = $clog2(MAX_BLOCKS);
  localparam int BCNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int RIDX_W = $clog2(MAX_REQUESTS);
  localparam int RCNT_W = $clog2(MAX_REQUESTS + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd0;
  localparam logic [2:0] CFG_MAX_REQ     = 3'd1;
  localparam logic [2:0] CFG_BIT_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_WORD_LIMIT  = 3'd3;

  typedef struct packed {
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] start;
    logic [15:0] quantity;
    logic        is_bit;
  } block_t;

  typedef struct packed {
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic        is_bit;
    logic [15:0] start;
    logic [15:0] quantity;
  } request_t;

  // Data bytes for a quantity: bits round up to whole bytes, registers take two bytes.
  function automatic logic [15:0] byte_size(input logic [15:0] q, input logic is_bit);
    logic [16:0] sum;
    sum = {1'b0, q} + 17'd7;
    if (is_bit) begin
      byte_size = sum[16:3] > 14'd0 ? {2'b00, sum[16:3]} : 16'd0;
    end else begin
      byte_size = {q[14:0], 1'b0};
    end
  endfunction

endpackage

// File: rtl/core/ffd_request_packer.sv
// Top level of the first-fit-decreasing read request packer.
// Loads take one cycle each and busy stays low, so blocks may be loaded back to back. A pack
// command on a non-empty, non-overflowed store raises busy until its last result is issued;
// results appear one per strobe and cannot be held off. The stable sort passes SORT_RD and
// SORT_CHK for every loaded block at each rank, each first-fit search passes FIT_RD, FIT_MQ
// and FIT_CHK for every request examined, plus a FIT_RD when the block opens a new request,
// and each result passes EMIT_RD and EMIT_OUT. An overflowed or empty store gives its single
// result on the cycle after the command; a request-limit error is issued on the cycle after
// the search that finds no room for a new request. No clearing pass is needed.
module ffd_request_packer import ffd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  unit_id,
  input  logic [7:0]  func_code,
  input  logic [15:0] block_start,
  input  logic [15:0] block_quantity,
  input  logic        unit_is_bit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [7:0]  out_unit_id,
  output logic [7:0]  out_func_code,
  output logic [15:0] out_start,
  output logic [15:0] out_quantity,
  output logic [15:0] out_bytes,
  output logic        out_last,
  output logic [1:0]  out_status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SORT_RD  = 3'd1;
  localparam logic [2:0] S_SORT_CHK = 3'd2;
  localparam logic [2:0] S_FIT_RD   = 3'd3;
  localparam logic [2:0] S_FIT_MQ   = 3'd4;
  localparam logic [2:0] S_FIT_CHK  = 3'd5;
  localparam logic [2:0] S_EMIT_RD  = 3'd6;
  localparam logic [2:0] S_EMIT_OUT = 3'd7;

  logic [2:0]  state;
  logic [15:0] max_payload;
  logic [5:0]  max_req;
  logic [15:0] bit_limit;
  logic [15:0] word_limit;

  block_t      bmem [MAX_BLOCKS];
  block_t      brd;
  request_t    rmem [MAX_REQUESTS];
  request_t    rrd;

  logic [BCNT_W-1:0] blk_fill;
  logic              overflow;
  logic [RCNT_W-1:0] request_count;
  logic [BIDX_W-1:0] sidx;
  logic [BCNT_W-1:0] rank;
  logic [RCNT_W-1:0] ridx;
  logic              first;
  logic              have;
  block_t            best;
  logic [BIDX_W-1:0] bidx;
  logic [15:0]       prev_q;
  logic [BIDX_W-1:0] prev_idx;
  logic              key_match;
  logic [15:0]       m_lo;
  logic [15:0]       m_q;

  logic              accept;
  logic              cand;
  logic [RCNT_W-1:0] limit;
  logic [16:0]       be;
  logic [16:0]       re;
  logic [16:0]       hi;
  logic [15:0]       lo;
  logic [15:0]       qlim;
  logic              fits;
  logic              last_rank;
  request_t          new_req;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cand = first || (brd.quantity < prev_q) ||
                ((brd.quantity == prev_q) && (sidx > prev_idx));
  assign limit = (max_req > 6'(MAX_REQUESTS)) ? RCNT_W'(MAX_REQUESTS) : RCNT_W'(max_req);

  // Merged span of the current block with the request just read.
  assign lo   = (best.start < rrd.start) ? best.start : rrd.start;
  assign be   = {1'b0, best.start} + {1'b0, best.quantity};
  assign re   = {1'b0, rrd.start} + {1'b0, rrd.quantity};
  assign hi   = (be > re) ? be : re;
  assign qlim = best.is_bit ? bit_limit : word_limit;
  assign fits = key_match && (m_q <= qlim) && (byte_size(m_q, best.is_bit) <= max_payload);
  assign last_rank = (rank + BCNT_W'(1)) == blk_fill;
  assign new_req = '{unit_id: best.unit_id, func_code: best.func_code, is_bit: best.is_bit,
                     start: best.start, quantity: best.quantity};

  always_ff @(posedge clk) begin
    if (accept && !op && (blk_fill < BCNT_W'(MAX_BLOCKS))) begin
      bmem[blk_fill[BIDX_W-1:0]] <= '{unit_id: unit_id, func_code: func_code,
                                      start: block_start, quantity: block_quantity,
                                      is_bit: unit_is_bit};
    end
    brd <= bmem[sidx];
  end

  always_ff @(posedge clk) begin
    if (state == S_FIT_RD && ridx == request_count && request_count < limit) begin
      rmem[ridx[RIDX_W-1:0]] <= new_req;
    end else if (state == S_FIT_CHK && fits) begin
      rmem[ridx[RIDX_W-1:0]] <= '{unit_id: best.unit_id, func_code: best.func_code,
                                  is_bit: best.is_bit, start: m_lo, quantity: m_q};
    end
    rrd <= rmem[ridx[RIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= 16'd250;
      max_req     <= 6'd32;
      bit_limit   <= 16'd2000;
      word_limit  <= 16'd125;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD: max_payload <= cfg_data;
        CFG_MAX_REQ:     max_req     <= cfg_data[5:0];
        CFG_BIT_LIMIT:   bit_limit   <= cfg_data;
        CFG_WORD_LIMIT:  word_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      blk_fill      <= '0;
      overflow      <= 1'b0;
      request_count <= '0;
      out_valid     <= 1'b0;
      sidx          <= '0;
      ridx          <= '0;
      rank          <= '0;
      first         <= 1'b0;
      have          <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && !op) begin
            if (blk_fill < BCNT_W'(MAX_BLOCKS)) begin
              blk_fill <= blk_fill + BCNT_W'(1);
            end else begin
              overflow <= 1'b1;
            end
          end else if (accept) begin
            request_count <= '0;
            if (overflow || blk_fill == '0) begin
              out_valid     <= 1'b1;
              out_unit_id   <= '0;
              out_func_code <= '0;
              out_start     <= '0;
              out_quantity  <= '0;
              out_bytes     <= '0;
              out_last      <= 1'b1;
              out_status    <= overflow ? ST_OVERFLOW : ST_EMPTY;
              blk_fill      <= '0;
              overflow      <= 1'b0;
            end else begin
              sidx  <= '0;
              rank  <= '0;
              first <= 1'b1;
              have  <= 1'b0;
              state <= S_SORT_RD;
            end
          end
        end
        S_SORT_RD: state <= S_SORT_CHK;
        S_SORT_CHK: begin
          // Strictly larger wins, so among equal quantities the earliest load is kept.
          if (cand && (!have || brd.quantity > best.quantity)) begin
            best <= brd;
            bidx <= sidx;
            have <= 1'b1;
          end
          if (BCNT_W'(sidx) + BCNT_W'(1) == blk_fill) begin
            ridx  <= '0;
            state <= S_FIT_RD;
          end else begin
            sidx  <= sidx + BIDX_W'(1);
            state <= S_SORT_RD;
          end
        end
        S_FIT_RD: begin
          if (ridx == request_count) begin
            if (request_count >= limit) begin
              out_valid     <= 1'b1;
              out_unit_id   <= '0;
              out_func_code <= '0;
              out_start     <= '0;
              out_quantity  <= '0;
              out_bytes     <= '0;
              out_last      <= 1'b1;
              out_status    <= ST_TOO_MANY;
              request_count <= '0;
              blk_fill      <= '0;
              overflow      <= 1'b0;
              state         <= S_IDLE;
            end else begin
              request_count <= request_count + RCNT_W'(1);
              if (last_rank) begin
                ridx  <= '0;
                state <= S_EMIT_RD;
              end else begin
                rank     <= rank + BCNT_W'(1);
                sidx     <= '0;
                first    <= 1'b0;
                have     <= 1'b0;
                prev_q   <= best.quantity;
                prev_idx <= bidx;
                state    <= S_SORT_RD;
              end
            end
          end else begin
            state <= S_FIT_MQ;
          end
        end
        S_FIT_MQ: begin
          key_match <= (rrd.unit_id == best.unit_id) && (rrd.func_code == best.func_code) &&
                       (rrd.is_bit == best.is_bit);
          m_lo      <= lo;
          m_q       <= 16'(hi - {1'b0, lo});
          state     <= S_FIT_CHK;
        end
        S_FIT_CHK: begin
          if (fits) begin
            if (last_rank) begin
              ridx  <= '0;
              state <= S_EMIT_RD;
            end else begin
              rank     <= rank + BCNT_W'(1);
              sidx     <= '0;
              first    <= 1'b0;
              have     <= 1'b0;
              prev_q   <= best.quantity;
              prev_idx <= bidx;
              state    <= S_SORT_RD;
            end
          end else begin
            ridx  <= ridx + RCNT_W'(1);
            state <= S_FIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_OUT;
        S_EMIT_OUT: begin
          out_valid     <= 1'b1;
          out_unit_id   <= rrd.unit_id;
          out_func_code <= rrd.func_code;
          out_start     <= rrd.start;
          out_quantity  <= rrd.quantity;
          out_bytes     <= byte_size(rrd.quantity, rrd.is_bit);
          out_last      <= (ridx + RCNT_W'(1)) == request_count;
          out_status    <= ST_OK;
          if ((ridx + RCNT_W'(1)) == request_count) begin
            blk_fill <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end else begin
            ridx  <= ridx + RCNT_W'(1);
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_blk_fill_range: assert property (@(posedge clk) disable iff (rst)
    blk_fill <= BCNT_W'(MAX_BLOCKS)) else $error("block count beyond store depth");

  a_request_count_range: assert property (@(posedge clk) disable iff (rst)
    request_count <= RCNT_W'(MAX_REQUESTS)) else $error("request count beyond store depth");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_last && out_quantity == 16'd0)
    else $error("error item not final or not zeroed");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !busy && blk_fill == '0 && !overflow)
    else $error("run did not finish with its last item");

endmodule

// File: bench/ffd_request_packer_chk.sv
// Checker for the request packer: follows every handshake, predicts the packed requests and compares them.
module ffd_request_packer_chk import ffd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [7:0]  unit_id,
  input  logic [7:0]  func_code,
  input  logic [15:0] block_start,
  input  logic [15:0] block_quantity,
  input  logic        unit_is_bit,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic [7:0]  out_unit_id,
  input  logic [7:0]  out_func_code,
  input  logic [15:0] out_start,
  input  logic [15:0] out_quantity,
  input  logic [15:0] out_bytes,
  input  logic        out_last,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  uid;
    logic [7:0]  fc;
    logic [15:0] st;
    logic [15:0] qty;
    logic [15:0] nbytes;
    logic        last;
    logic [1:0]  status;
  } packed_req_t;

  packed_req_t expected_reqs[$];

  logic [15:0] lim_payload = 16'd250;
  logic [5:0]  lim_requests = 6'd32;
  logic [15:0] lim_bits = 16'd2000;
  logic [15:0] lim_words = 16'd125;

  block_t      held[MAX_BLOCKS];
  int          held_count = 0;
  logic        store_overflowed = 1'b0;

  assign pending = expected_reqs.size();

  function automatic logic [15:0] data_bytes(input logic [15:0] q, input logic is_bit);
    logic [16:0] sum;
    sum = {1'b0, q} + 17'd7;
    data_bytes = is_bit ? {2'b00, sum[16:3]} : {q[14:0], 1'b0};
  endfunction

  task automatic push_error(input logic [1:0] code);
    packed_req_t r;
    r = '0;
    r.last = 1'b1;
    r.status = code;
    expected_reqs.push_back(r);
  endtask

  task automatic predict_pack();
    int          order[MAX_BLOCKS];
    logic [7:0]  r_uid[MAX_REQUESTS];
    logic [7:0]  r_fc[MAX_REQUESTS];
    logic        r_bit[MAX_REQUESTS];
    logic [15:0] r_start[MAX_REQUESTS];
    logic [15:0] r_qty[MAX_REQUESTS];
    int          nreq, cap, j, k;
    logic [31:0] lo, hi, be, re;
    logic [15:0] mq, qlim;
    logic        placed;
    block_t      b;
    packed_req_t r;
    if (store_overflowed) begin
      push_error(ST_OVERFLOW);
    end else if (held_count == 0) begin
      push_error(ST_EMPTY);
    end else begin
      // Insertion sort keeps load order among equal quantities.
      for (int i = 0; i < held_count; i++) begin
        j = i;
        while (j > 0 && held[order[j-1]].quantity < held[i].quantity) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      cap = (lim_requests < MAX_REQUESTS) ? int'(lim_requests) : MAX_REQUESTS;
      nreq = 0;
      for (int i = 0; i < held_count; i++) begin
        b = held[order[i]];
        qlim = b.is_bit ? lim_bits : lim_words;
        placed = 1'b0;
        for (k = 0; k < nreq && !placed; k++) begin
          if (r_uid[k] == b.unit_id && r_fc[k] == b.func_code && r_bit[k] == b.is_bit) begin
            lo = 32'((b.start < r_start[k]) ? b.start : r_start[k]);
            be = 32'(b.start) + 32'(b.quantity);
            re = 32'(r_start[k]) + 32'(r_qty[k]);
            hi = (be > re) ? be : re;
            mq = 16'(hi - lo);
            if (mq <= qlim && data_bytes(mq, b.is_bit) <= lim_payload) begin
              r_start[k] = lo[15:0];
              r_qty[k] = mq;
              placed = 1'b1;
            end
          end
        end
        if (!placed) begin
          if (nreq >= cap) begin
            push_error(ST_TOO_MANY);
            return;
          end
          r_uid[nreq] = b.unit_id;
          r_fc[nreq] = b.func_code;
          r_bit[nreq] = b.is_bit;
          r_start[nreq] = b.start;
          r_qty[nreq] = b.quantity;
          nreq++;
        end
      end
      for (k = 0; k < nreq; k++) begin
        r.uid = r_uid[k];
        r.fc = r_fc[k];
        r.st = r_start[k];
        r.qty = r_qty[k];
        r.nbytes = data_bytes(r_qty[k], r_bit[k]);
        r.last = (k == nreq - 1);
        r.status = ST_OK;
        expected_reqs.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    packed_req_t e;
    if (rst) begin
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD: lim_payload = cfg_data;
          CFG_MAX_REQ:     lim_requests = cfg_data[5:0];
          CFG_BIT_LIMIT:   lim_bits = cfg_data;
          CFG_WORD_LIMIT:  lim_words = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_reqs.size() == 0) begin
          $display("%0t: unexpected result unit %0d fc %0d start %0d qty %0d status %0d",
                   $time, out_unit_id, out_func_code, out_start, out_quantity, out_status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_reqs.pop_front();
          if (e !== {out_unit_id, out_func_code, out_start, out_quantity, out_bytes,
                     out_last, out_status}) begin
            $display("%0t: mismatch expected uid %0d fc %0d start %0d qty %0d bytes %0d last %0d st %0d",
                     $time, e.uid, e.fc, e.st, e.qty, e.nbytes, e.last, e.status);
            $display("%0t:          actual   uid %0d fc %0d start %0d qty %0d bytes %0d last %0d st %0d",
                     $time, out_unit_id, out_func_code, out_start, out_quantity, out_bytes,
                     out_last, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (op) begin
          predict_pack();
          held_count = 0;
          store_overflowed = 1'b0;
        end else if (held_count >= MAX_BLOCKS) begin
          store_overflowed = 1'b1;
        end else begin
          held[held_count] = '{unit_id, func_code, block_start, block_quantity, unit_is_bit};
          held_count++;
        end
      end
    end
  end

endmodule

// File: bench/ffd_request_packer_tb.sv
// Top of the request packer testbench: clock, reset, stimulus, watchdog and verdict.
module ffd_request_packer_tb import ffd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = 1'b0;
  logic [7:0]  unit_id = '0;
  logic [7:0]  func_code = '0;
  logic [15:0] block_start = '0;
  logic [15:0] block_quantity = '0;
  logic        unit_is_bit = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        busy, cfg_ready, out_valid, out_last;
  logic [7:0]  out_unit_id, out_func_code;
  logic [15:0] out_start, out_quantity, out_bytes;
  logic [1:0]  out_status;
  int          fail_count, pending, results_seen;
  int          idle_pct = 35;
  int          items_sent = 0;
  int          packs_sent = 0;
  int          quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ffd_request_packer dut (.*);
  ffd_request_packer_chk chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[ffd_request_packer] ERROR");
        $finish;
      end
    end
  end

  // A pack always lowers start afterwards so that it cannot be taken twice.
  task automatic issue(input logic o, input logic [7:0] u, input logic [7:0] f,
                       input logic [15:0] s, input logic [15:0] q, input logic b);
    start <= 1'b1;
    op <= o;
    unit_id <= u;
    func_code <= f;
    block_start <= s;
    block_quantity <= q;
    unit_is_bit <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (o) packs_sent++;
    if (o || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load(input logic [7:0] u, input logic [7:0] f, input logic [15:0] s,
                      input logic [15:0] q, input logic b);
    issue(1'b0, u, f, s, q, b);
  endtask

  task automatic pack();
    issue(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] pay, input logic [15:0] nreq,
                            input logic [15:0] bits, input logic [15:0] words);
    wait_drained();
    write_reg(CFG_MAX_PAYLOAD, pay);
    write_reg(CFG_MAX_REQ, nreq);
    write_reg(CFG_BIT_LIMIT, bits);
    write_reg(CFG_WORD_LIMIT, words);
  endtask

  // Mostly small clustered batches so that merges happen; now and then full-range noise.
  task automatic random_batch(input int nblocks);
    logic [7:0]  u, f;
    logic [15:0] s, q;
    logic        b;
    for (int i = 0; i < nblocks; i++) begin
      if ($urandom_range(9) == 0) begin
        u = 8'($urandom);
        f = 8'($urandom);
        s = 16'($urandom);
        q = 16'($urandom);
        b = 1'($urandom);
      end else begin
        u = 8'($urandom_range(1, 2));
        f = $urandom_range(1) ? 8'd3 : 8'd1;
        s = 16'($urandom_range(0, 300));
        q = 16'($urandom_range(0, 80));
        b = (f == 8'd1);
        if ($urandom_range(19) == 0) s = 16'($urandom_range(65400, 65535));
      end
      load(u, f, s, q, b);
    end
    pack();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty run, field extremes, wrapped merge.
    pack();
    load(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    load(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    load(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    pack();
    load(8'd5, 8'd3, 16'd65530, 16'd10, 1'b0);
    load(8'd5, 8'd3, 16'd0, 16'd5, 1'b0);
    load(8'd5, 8'd3, 16'd20, 16'd10, 1'b0);
    load(8'd5, 8'd3, 16'd20, 16'd10, 1'b1);
    load(8'd6, 8'd3, 16'd20, 16'd10, 1'b0);
    pack();
    // Request limit of zero refuses any non-empty run; a limit of one refuses two keys.
    set_limits(16'd0, 16'd0, 16'd1, 16'd1);
    load(8'd1, 8'd1, 16'd10, 16'd300, 1'b1);
    pack();
    set_limits(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    load(8'd1, 8'd3, 16'd0, 16'd4, 1'b0);
    load(8'd1, 8'd3, 16'd100, 16'd4, 1'b0);
    load(8'd2, 8'd3, 16'd0, 16'd4, 1'b0);
    pack();
    // A store overfilled by one block gives the overflow status.
    set_limits(16'd250, 16'd63, 16'd2000, 16'd125);
    random_batch(MAX_BLOCKS + 1);

    // Random part over several settings, extremes among them.
    for (int ph = 0; items_sent < 280; ph++) begin
      if (items_sent > 280 / 3) idle_pct = 78;
      if (items_sent > 2 * 280 / 3) idle_pct = 0;
      else if (items_sent <= 280 / 3) idle_pct = 35;
      case (ph % 6)
        0: set_limits(16'd250, 16'd32, 16'd2000, 16'd125);
        1: set_limits(16'hFFFF, 16'd63, 16'hFFFF, 16'hFFFF);
        2: set_limits(16'd0, 16'd1, 16'd1, 16'd1);
        3: set_limits(16'($urandom_range(0, 200)), 16'($urandom_range(0, 63)),
                      16'($urandom_range(1, 400)), 16'($urandom_range(1, 100)));
        4: set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: set_limits(16'd40, 16'd4, 16'd150, 16'd20);
      endcase
      for (int n = 0; n < 4; n++) begin
        if (ph == 1 && n == 0) random_batch(MAX_BLOCKS);
        else random_batch($urandom_range(0, 14));
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d items including %0d pack commands, %0d results checked.",
             items_sent, packs_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ffd_request_packer] OK");
    end else begin
      $display("[ffd_request_packer] ERROR");
    end
    $finish;
  end

endmodule
